/* design/gmw_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmw_pkg: shared types and constants of the grid maze walker
// Headings, action codes, register indexes, walker state and helper
// functions for neighbor coordinates.
// ----------------------------------------------------------------------------
package gmw_pkg;

  // Map geometry: the stored map is at most MapSide x MapSide cells
  localparam int MapSide       = 32;
  localparam int GridRowsDef   = 32;
  localparam int GridColsDef   = 32;

  // Headings
  localparam logic [1:0] HEAD_N = 2'd0;
  localparam logic [1:0] HEAD_E = 2'd1;
  localparam logic [1:0] HEAD_S = 2'd2;
  localparam logic [1:0] HEAD_W = 2'd3;

  // Item kinds
  localparam logic [1:0] ACT_LOAD    = 2'd0;
  localparam logic [1:0] ACT_STEP    = 2'd1;
  localparam logic [1:0] ACT_RESTART = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] CFG_START_ROW = 3'd0;
  localparam logic [2:0] CFG_START_COL = 3'd1;
  localparam logic [2:0] CFG_GOAL_ROW  = 3'd2;
  localparam logic [2:0] CFG_GOAL_COL  = 3'd3;
  localparam logic [2:0] CFG_WALK_MODE = 3'd4;

  // Walk modes
  localparam logic MODE_PLEDGE = 1'b0;
  localparam logic MODE_RIGHT  = 1'b1;

  // Counter bounds
  localparam logic signed [7:0] TURNS_MIN = 8'sh80;
  localparam logic signed [7:0] TURNS_MAX = 8'sh7f;
  localparam logic [15:0]       STEPS_MAX = 16'hffff;

  // Robot pose and Pledge counter
  typedef struct packed {
    logic [4:0]        row;
    logic [4:0]        col;
    logic [1:0]        facing;
    logic signed [7:0] turns;
  } walker_t;

  // Outcome of one decision step
  typedef struct packed {
    walker_t w;
    logic    moved;
  } step_res_t;

  // Row of the neighbor in direction d; -1 wraps to 63, so it reads as outside
  function automatic logic [5:0] nb_row(input logic [4:0] r, input logic [1:0] d);
    logic [5:0] res;
    case (d)
      HEAD_N:  res = {1'b0, r} - 6'd1;
      HEAD_S:  res = {1'b0, r} + 6'd1;
      default: res = {1'b0, r};
    endcase
    return res;
  endfunction

  // Column of the neighbor in direction d
  function automatic logic [5:0] nb_col(input logic [4:0] c, input logic [1:0] d);
    logic [5:0] res;
    case (d)
      HEAD_E:  res = {1'b0, c} + 6'd1;
      HEAD_W:  res = {1'b0, c} - 6'd1;
      default: res = {1'b0, c};
    endcase
    return res;
  endfunction

endpackage

/* design/gmw_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmw_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data that holds
// while no read is issued.
// ----------------------------------------------------------------------------
module gmw_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/gmw_step.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmw_step: one decision step of the walker
// Given the pose and whether the cells ahead and to the side are blocked,
// pick the new heading, position and turn count (Pledge or right hand).
// ----------------------------------------------------------------------------
module gmw_step (
  input  gmw_pkg::walker_t   cur,
  input  logic               mode,
  input  logic               ahead_blk,
  input  logic               side_blk,
  output gmw_pkg::step_res_t res
);
  import gmw_pkg::*;

  logic [1:0]        dir_left;
  logic [1:0]        dir_right;
  logic signed [7:0] turns_dec;
  logic signed [7:0] turns_inc;
  logic              go;
  logic [1:0]        go_dir;
  logic [1:0]        new_facing;
  logic signed [7:0] new_turns;
  logic [5:0]        go_row;
  logic [5:0]        go_col;

  assign dir_left  = cur.facing + 2'd3;
  assign dir_right = cur.facing + 2'd1;
  assign turns_dec = (cur.turns == TURNS_MIN) ? cur.turns : cur.turns - 8'sd1;
  assign turns_inc = (cur.turns == TURNS_MAX) ? cur.turns : cur.turns + 8'sd1;

  // Choose turn and move
  always_comb begin
    go         = 1'b0;
    new_facing = cur.facing;
    new_turns  = cur.turns;
    if (mode == MODE_RIGHT) begin
      if (!side_blk) begin
        go         = 1'b1;
        new_facing = dir_right;
      end else if (!ahead_blk) begin
        go = 1'b1;
      end else begin
        new_facing = dir_left;
      end
    end else if (cur.turns == 8'sd0) begin
      if (!ahead_blk) begin
        go = 1'b1;
      end else begin
        new_facing = dir_right;
        new_turns  = turns_dec;
      end
    end else begin
      if (!side_blk) begin
        go         = 1'b1;
        new_facing = dir_left;
        new_turns  = turns_inc;
      end else if (!ahead_blk) begin
        go = 1'b1;
      end else begin
        new_facing = dir_right;
        new_turns  = turns_dec;
      end
    end
  end

  // Advance one cell along the new heading
  assign go_dir = new_facing;
  assign go_row = nb_row(cur.row, go_dir);
  assign go_col = nb_col(cur.col, go_dir);

  always_comb begin
    res.w.facing = new_facing;
    res.w.turns  = new_turns;
    res.moved    = go;
    res.w.row    = go ? go_row[4:0] : cur.row;
    res.w.col    = go ? go_col[4:0] : cur.col;
  end

endmodule

/* design/grid_maze_walker_pledge.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_maze_walker_pledge: robot walking a stored wall grid
// Load items fill the wall map, restart items place the robot, step items
// run one Pledge or right-hand wall follower step. One result per item.
// ----------------------------------------------------------------------------
//  channel  handshake               payload
//  s_*      s_tvalid / s_tready     s_tdata: action, cell_row, cell_col, wall_bit
//  m_*      m_tvalid / m_tready     m_tdata: row, col, heading, moved, arrived,
//                                            turn_count, steps_taken
//  cfg_*    cfg_valid / cfg_ready   cfg_index, cfg_data (always ready)
//
//  When an item is taken the reads of the cell ahead and the side cell go to
//  the two map copies; the decision stage then decides and updates the
//  pose, which the next item's read addresses need.
//  After reset a clearing pass writes every map cell open, one per cycle
//  (GRID_ROWS*32 cells with GRID_ROWS capped at 32); s_tready stays low.
//  A held result in the output register stalls the decision stage; no new
//  item is taken while an item waits there.
// ----------------------------------------------------------------------------
module grid_maze_walker_pledge #(
  parameter int GRID_ROWS = gmw_pkg::GridRowsDef,
  parameter int GRID_COLS = gmw_pkg::GridColsDef
) (
  input  logic        clk,
  input  logic        rst,
  // action[1:0], cell_row[6:2], cell_col[11:7], wall_bit[12], zero [15:13]
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,
  // robot_row[4:0], robot_col[9:5], heading[11:10], moved[12], arrived[13],
  // turn_count[21:14], steps_taken[37:22], zero [39:38]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [4:0]  cfg_data
);
  import gmw_pkg::*;

  localparam int RowsEff = (GRID_ROWS < MapSide) ? GRID_ROWS : MapSide;
  localparam int ColsEff = (GRID_COLS < MapSide) ? GRID_COLS : MapSide;
  localparam int Depth   = RowsEff * MapSide;
  localparam int AddrW   = $clog2(Depth);

  // Configuration registers
  logic [4:0] start_row;
  logic [4:0] start_col;
  logic [4:0] goal_row;
  logic [4:0] goal_col;
  logic       walk_mode;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_row <= 5'd0;
      start_col <= 5'd0;
      goal_row  <= 5'd31;
      goal_col  <= 5'd31;
      walk_mode <= MODE_PLEDGE;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_START_ROW: start_row <= cfg_data;
        CFG_START_COL: start_col <= cfg_data;
        CFG_GOAL_ROW:  goal_row  <= cfg_data;
        CFG_GOAL_COL:  goal_col  <= cfg_data;
        CFG_WALK_MODE: walk_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Input fields
  logic [1:0] in_action;
  logic [4:0] in_row;
  logic [4:0] in_col;
  logic       in_wall;

  assign in_action = s_tdata[1:0];
  assign in_row    = s_tdata[6:2];
  assign in_col    = s_tdata[11:7];
  assign in_wall   = s_tdata[12];

  // Walker state and pipeline control
  walker_t    walker;
  logic [15:0] steps;
  logic       clr_busy;
  logic [AddrW-1:0] clr_addr;
  logic       s1_valid;
  logic       s1_fire;
  logic       s_fire;

  assign s_tready = !clr_busy && !s1_valid;
  assign s_fire   = s_tvalid && s_tready;
  assign s1_fire  = s1_valid && (!m_tvalid || m_tready);

  // Neighbor cells: ahead and to the side (left for Pledge, right otherwise)
  logic [1:0] side_dir;
  logic [5:0] ah_row;
  logic [5:0] ah_col;
  logic [5:0] sd_row;
  logic [5:0] sd_col;
  logic       ah_oob;
  logic       sd_oob;

  assign side_dir = (walk_mode == MODE_RIGHT) ? walker.facing + 2'd1
                                              : walker.facing + 2'd3;
  assign ah_row = nb_row(walker.row, walker.facing);
  assign ah_col = nb_col(walker.col, walker.facing);
  assign sd_row = nb_row(walker.row, side_dir);
  assign sd_col = nb_col(walker.col, side_dir);
  assign ah_oob = !(ah_row < 6'(RowsEff) && ah_col < 6'(ColsEff));
  assign sd_oob = !(sd_row < 6'(RowsEff) && sd_col < 6'(ColsEff));

  // Stage one holding registers
  logic [1:0] s1_action;
  logic [4:0] s1_row;
  logic [4:0] s1_col;
  logic       s1_wall;
  logic       s1_ah_oob;
  logic       s1_sd_oob;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      s1_action <= in_action;
      s1_row    <= in_row;
      s1_col    <= in_col;
      s1_wall   <= in_wall;
      s1_ah_oob <= ah_oob;
      s1_sd_oob <= sd_oob;
    end
  end

  // Clearing pass after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      clr_addr <= clr_addr + AddrW'(1);
      if (clr_addr == AddrW'(Depth - 1)) begin
        clr_busy <= 1'b0;
      end
    end
  end

  // Map write port, shared by the clearing pass and load items
  logic             ld_in_grid;
  logic             map_we;
  logic [AddrW-1:0] map_waddr;
  logic             map_wdata;
  logic             ah_wall;
  logic             sd_wall;

  assign ld_in_grid = ({1'b0, s1_row} < 6'(RowsEff)) && ({1'b0, s1_col} < 6'(ColsEff));
  assign map_we     = clr_busy || (s1_fire && s1_action == ACT_LOAD && ld_in_grid);
  assign map_waddr  = clr_busy ? clr_addr : AddrW'({s1_row, s1_col});
  assign map_wdata  = clr_busy ? 1'b0 : s1_wall;

  // Two copies of the map so both neighbors are read in the same cycle
  gmw_ram #(.WIDTH(1), .DEPTH(Depth)) u_map_ahead (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .re    (s_fire),
    .raddr (AddrW'({ah_row[4:0], ah_col[4:0]})),
    .rdata (ah_wall)
  );

  gmw_ram #(.WIDTH(1), .DEPTH(Depth)) u_map_side (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .re    (s_fire),
    .raddr (AddrW'({sd_row[4:0], sd_col[4:0]})),
    .rdata (sd_wall)
  );

  // Decision step
  step_res_t step_res;
  logic      at_goal;

  assign at_goal = (walker.row == goal_row) && (walker.col == goal_col);

  gmw_step u_step (
    .cur       (walker),
    .mode      (walk_mode),
    .ahead_blk (s1_ah_oob || ah_wall),
    .side_blk  (s1_sd_oob || sd_wall),
    .res       (step_res)
  );

  // Next walker state for the item in stage one
  walker_t     walker_next;
  logic [15:0] steps_next;
  logic        moved_next;

  always_comb begin
    walker_next = walker;
    steps_next  = steps;
    moved_next  = 1'b0;
    case (s1_action)
      ACT_STEP: begin
        if (!at_goal) begin
          walker_next = step_res.w;
          moved_next  = step_res.moved;
          if (steps != STEPS_MAX) begin
            steps_next = steps + 16'd1;
          end
        end
      end
      ACT_RESTART: begin
        walker_next.row    = start_row;
        walker_next.col    = start_col;
        walker_next.facing = HEAD_N;
        walker_next.turns  = 8'sd0;
        steps_next         = 16'd0;
      end
      default: ;
    endcase
  end

  // Commit state
  always_ff @(posedge clk) begin
    if (rst) begin
      walker <= '0;
      steps  <= 16'd0;
    end else if (s1_fire) begin
      walker <= walker_next;
      steps  <= steps_next;
    end
  end

  // Output register
  logic arrived_next;

  assign arrived_next = (walker_next.row == goal_row) && (walker_next.col == goal_col);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      m_tdata <= {2'b00, steps_next, walker_next.turns, arrived_next, moved_next,
                  walker_next.facing, walker_next.col, walker_next.row};
    end
  end

  // Checks
  ap_no_take_in_clear: assert property (@(posedge clk) disable iff (rst)
    clr_busy |-> !s_tready)
    else $error("item taken during map clearing pass");

  ap_take_to_stage: assert property (@(posedge clk) disable iff (rst)
    s_fire |=> s1_valid)
    else $error("taken item did not reach the decision stage");

  ap_stage_to_out: assert property (@(posedge clk) disable iff (rst)
    s1_fire |=> m_tvalid)
    else $error("decided item did not reach the output register");

  ap_rh_turns: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && s1_action == ACT_STEP && walk_mode == MODE_RIGHT) |=> $stable(walker.turns))
    else $error("turn counter changed in right-hand mode");

endmodule

/* tb/grid_maze_walker_pledge_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_maze_walker_pledge_test: self-checking bench for the maze walker
// Feeds load, step and restart items through the stream port, keeps its own
// copy of the wall map and the robot pose, and compares every result field
// by field. Covers both walk modes, edges of the grid, a fully boxed-in
// robot until the turn counter saturates, and random mazes around the start.
// ----------------------------------------------------------------------------
module grid_maze_walker_pledge_test;
  import gmw_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int LONG_HOLD   = 60;
  // unused action code, the block reports its state and does nothing else
  localparam logic [1:0] ACT_NONE = 2'd3;

  // result fields, last field in the lowest bits
  typedef struct packed {
    logic [15:0]       steps;
    logic signed [7:0] turns;
    logic              arrived;
    logic              moved;
    logic [1:0]        head;
    logic [4:0]        col;
    logic [4:0]        row;
  } pose_report_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [4:0]  cfg_data = '0;

  grid_maze_walker_pledge u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // stimulus and expectation stores
  logic [15:0]  maze_items[$];
  pose_report_t expected_poses[$];

  bit idle_on = 1'b1;
  bit item_taken;
  int src_gap;
  bit hold_req;
  int hold_left;
  int sink_gap;
  int err_count;
  int cycle_count;

  // walker copy: map, pose, counters and registers
  logic       map_wall [0:MapSide*MapSide-1];
  logic [4:0] bot_row, bot_col;
  logic [1:0] bot_head;
  int         bot_turns, bot_steps;
  logic [4:0] start_row_q = 5'd0, start_col_q = 5'd0;
  logic [4:0] goal_row_q = 5'd31, goal_col_q = 5'd31;
  logic       mode_q = MODE_PLEDGE;

  // append one item to the send queue
  function automatic void add_item(logic [15:0] item);
    maze_items.insert(maze_items.size(), item);
  endfunction

  function automatic logic [15:0] pack_item(logic [1:0] act, logic [4:0] r, logic [4:0] c,
                                            logic w);
    return {3'b000, w, c, r, act};
  endfunction

  function automatic logic [15:0] random_item(logic [1:0] act);
    return pack_item(act, 5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                     1'($urandom_range(0, 1)));
  endfunction

  // random cell coordinate within span of base, clipped to the map
  function automatic logic [4:0] near(logic [4:0] base, int span);
    int v;
    v = int'(base) + int'($urandom_range(0, 2 * span)) - span;
    if (v < 0) v = 0;
    if (v > 31) v = 31;
    return v[4:0];
  endfunction

  // neighbor in direction dir is a wall or off the grid
  function automatic logic cell_blocked(logic [1:0] dir);
    int r, c;
    r = int'(bot_row);
    c = int'(bot_col);
    case (dir)
      HEAD_N:  r = r - 1;
      HEAD_E:  c = c + 1;
      HEAD_S:  r = r + 1;
      default: c = c - 1;
    endcase
    if (r < 0 || c < 0 || r >= MapSide || c >= MapSide || r >= GridRowsDef || c >= GridColsDef)
      return 1'b1;
    return map_wall[r * MapSide + c];
  endfunction

  function automatic void bot_advance();
    case (bot_head)
      HEAD_N:  bot_row = bot_row - 5'd1;
      HEAD_E:  bot_col = bot_col + 5'd1;
      HEAD_S:  bot_row = bot_row + 5'd1;
      default: bot_col = bot_col - 5'd1;
    endcase
  endfunction

  function automatic logic on_goal();
    return bot_row == goal_row_q && bot_col == goal_col_q;
  endfunction

  // one decision step in the current mode; returns the move flag
  function automatic logic walk_decide();
    if (mode_q == MODE_RIGHT) begin
      bot_head = bot_head + 2'd1;
      if (!cell_blocked(bot_head)) begin
        bot_advance();
        return 1'b1;
      end
      bot_head = bot_head - 2'd1;
      if (!cell_blocked(bot_head)) begin
        bot_advance();
        return 1'b1;
      end
      bot_head = bot_head - 2'd1;
      return 1'b0;
    end
    // Pledge: with a nonzero counter prefer the left turn
    if (bot_turns != 0 && !cell_blocked(bot_head - 2'd1)) begin
      bot_head = bot_head - 2'd1;
      if (bot_turns < 127) bot_turns++;
      bot_advance();
      return 1'b1;
    end
    if (!cell_blocked(bot_head)) begin
      bot_advance();
      return 1'b1;
    end
    bot_head = bot_head + 2'd1;
    if (bot_turns > -128) bot_turns--;
    return 1'b0;
  endfunction

  // apply one accepted item and queue the pose it must report
  function automatic void advance_walker(logic [15:0] item);
    logic [1:0]   act;
    logic [4:0]   r, c;
    logic         mv;
    pose_report_t rep;
    act = item[1:0];
    r   = item[6:2];
    c   = item[11:7];
    mv  = 1'b0;
    case (act)
      ACT_LOAD: begin
        if (r < GridRowsDef && c < GridColsDef) map_wall[r * MapSide + c] = item[12];
      end
      ACT_STEP: begin
        if (!on_goal()) begin
          mv = walk_decide();
          if (bot_steps < STEPS_MAX) bot_steps++;
        end
      end
      ACT_RESTART: begin
        bot_row   = start_row_q;
        bot_col   = start_col_q;
        bot_head  = HEAD_N;
        bot_turns = 0;
        bot_steps = 0;
      end
      default: ;
    endcase
    rep.row     = bot_row;
    rep.col     = bot_col;
    rep.head    = bot_head;
    rep.moved   = mv;
    rep.arrived = on_goal();
    rep.turns   = bot_turns[7:0];
    rep.steps   = bot_steps[15:0];
    expected_poses.insert(expected_poses.size(), rep);
  endfunction

  function automatic void check_field(string fname, int want, int got);
    if (want != got) begin
      err_count++;
      $display("%0t: %s expected %0d, got %0d", $time, fname, want, got);
    end
  endfunction

  // watch both streams and the register channel
  always @(posedge clk) begin
    pose_report_t got, want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got = pose_report_t'(m_tdata[37:0]);
        if (expected_poses.size() == 0) begin
          err_count++;
          $display("%0t: result expected none, got %h", $time, m_tdata);
        end else begin
          want = expected_poses.pop_front();
          check_field("robot_row", want.row, got.row);
          check_field("robot_col", want.col, got.col);
          check_field("heading", want.head, got.head);
          check_field("moved", want.moved, got.moved);
          check_field("arrived", want.arrived, got.arrived);
          check_field("turn_count", want.turns, got.turns);
          check_field("steps_taken", want.steps, got.steps);
        end
      end
      if (s_tvalid && s_tready) begin
        advance_walker(s_tdata);
        item_taken = 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_START_ROW: start_row_q = cfg_data;
          CFG_START_COL: start_col_q = cfg_data;
          CFG_GOAL_ROW:  goal_row_q  = cfg_data;
          CFG_GOAL_COL:  goal_col_q  = cfg_data;
          CFG_WALK_MODE: mode_q      = cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  // sender: offer the next item, with short random gaps
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || item_taken) begin
      item_taken = 1'b0;
      if (src_gap > 0) begin
        src_gap--;
        s_tvalid <= 1'b0;
      end else if (maze_items.size() != 0) begin
        s_tdata  <= maze_items.pop_front();
        s_tvalid <= 1'b1;
        if (idle_on && $urandom_range(0, 3) == 0) src_gap = $urandom_range(1, 3);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver: random stalls plus one long hold-off on request
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = LONG_HOLD - 1;
      m_tready <= 1'b0;
    end else if (sink_gap > 0) begin
      sink_gap--;
      m_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      sink_gap = $urandom_range(0, 2);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[grid_maze_walker_pledge] ERROR");
      $finish;
    end
  end

  // hold until every queued item is sent and every result has come back
  task automatic drain_items();
    while (maze_items.size() != 0 || s_tvalid || expected_poses.size() != 0)
      @(posedge clk);
  endtask

  // write all five registers while the block is idle
  task automatic set_walk(logic [4:0] sr, logic [4:0] sc, logic [4:0] gr, logic [4:0] gc,
                          logic mode);
    logic [2:0] idx [5];
    logic [4:0] vals [5];
    idx  = '{CFG_START_ROW, CFG_START_COL, CFG_GOAL_ROW, CFG_GOAL_COL, CFG_WALK_MODE};
    vals = '{sr, sc, gr, gc, {4'b0000, mode}};
    drain_items();
    for (int i = 0; i < 5; i++) begin
      @(negedge clk);
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [4:0] sr, sc, gr, gc;
    int n;
    for (int i = 0; i < MapSide * MapSide; i++) map_wall[i] = 1'b0;
    bot_row   = '0;
    bot_col   = '0;
    bot_head  = HEAD_N;
    bot_turns = 0;
    bot_steps = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // unused code, a step before any restart, map corners, then a short
    // Pledge walk along the top edge around one wall into the goal
    set_walk(5'd0, 5'd0, 5'd0, 5'd3, MODE_PLEDGE);
    add_item(pack_item(ACT_NONE, 5'd31, 5'd31, 1'b1));
    add_item(pack_item(ACT_STEP, 5'd0, 5'd0, 1'b0));
    add_item(pack_item(ACT_LOAD, 5'd31, 5'd31, 1'b1));
    add_item(pack_item(ACT_LOAD, 5'd0, 5'd0, 1'b0));
    add_item(pack_item(ACT_LOAD, 5'd31, 5'd0, 1'b1));
    add_item(pack_item(ACT_LOAD, 5'd0, 5'd31, 1'b0));
    add_item(pack_item(ACT_RESTART, 5'd31, 5'd31, 1'b1));
    add_item(pack_item(ACT_LOAD, 5'd0, 5'd1, 1'b1));
    repeat (8) add_item(pack_item(ACT_STEP, 5'd0, 5'd0, 1'b0));
    add_item(pack_item(ACT_LOAD, 5'd0, 5'd1, 1'b0));
    add_item(pack_item(ACT_LOAD, 5'd31, 5'd31, 1'b0));

    // right-hand mode: start on the goal, then a boxed-in corner
    set_walk(5'd0, 5'd0, 5'd0, 5'd0, MODE_RIGHT);
    add_item(random_item(ACT_RESTART));
    add_item(random_item(ACT_STEP));
    set_walk(5'd0, 5'd0, 5'd31, 5'd31, MODE_RIGHT);
    add_item(pack_item(ACT_LOAD, 5'd1, 5'd0, 1'b1));
    add_item(pack_item(ACT_LOAD, 5'd0, 5'd1, 1'b1));
    add_item(random_item(ACT_RESTART));
    repeat (2) add_item(random_item(ACT_STEP));
    add_item(pack_item(ACT_LOAD, 5'd0, 5'd1, 1'b0));
    add_item(pack_item(ACT_LOAD, 5'd1, 5'd0, 1'b0));
    repeat (3) add_item(random_item(ACT_STEP));

    // boxed-in Pledge robot spins until the turn counter saturates
    set_walk(5'd0, 5'd0, 5'd31, 5'd31, MODE_PLEDGE);
    idle_on = 1'b0;
    add_item(pack_item(ACT_LOAD, 5'd0, 5'd1, 1'b1));
    add_item(pack_item(ACT_LOAD, 5'd1, 5'd0, 1'b1));
    add_item(random_item(ACT_RESTART));
    repeat (140) add_item(random_item(ACT_STEP));
    add_item(pack_item(ACT_LOAD, 5'd0, 5'd1, 1'b0));
    add_item(pack_item(ACT_LOAD, 5'd1, 5'd0, 1'b0));
    repeat (2) add_item(random_item(ACT_STEP));
    drain_items();
    idle_on = 1'b1;

    // random mazes around random start cells; the last walks run without gaps
    for (int ep = 0; ep < 10; ep++) begin
      if (ep == 8) idle_on = 1'b0;
      sr = ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? 5'd31 : 5'd0)
                                       : 5'($urandom_range(0, 31));
      sc = ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? 5'd31 : 5'd0)
                                       : 5'($urandom_range(0, 31));
      case ($urandom_range(0, 7))
        0: begin
          gr = sr;
          gc = sc;
        end
        1, 2, 3: begin
          gr = near(sr, 3);
          gc = near(sc, 3);
        end
        4, 5: begin
          gr = $urandom_range(0, 1) ? 5'd0 : 5'($urandom_range(0, 31));
          gc = (gr != 5'd0) ? 5'd31 : 5'($urandom_range(0, 31));
        end
        default: begin
          gr = 5'($urandom_range(0, 31));
          gc = 5'($urandom_range(0, 31));
        end
      endcase
      set_walk(sr, sc, gr, gc, logic'($urandom_range(0, 1)));

      // build walls near the start, a few anywhere, keep the goal open
      n = $urandom_range(15, 30);
      repeat (n)
        add_item(pack_item(ACT_LOAD, near(sr, 5), near(sc, 5),
                           $urandom_range(0, 2) == 0));
      repeat (3) add_item(random_item(ACT_LOAD));
      add_item(pack_item(ACT_LOAD, gr, gc, 1'b0));
      add_item(random_item(ACT_RESTART));

      // walk, with some noise mixed in
      n = $urandom_range(25, 45);
      repeat (n) begin
        case ($urandom_range(0, 24))
          0:       add_item(random_item(ACT_NONE));
          1:       add_item(random_item(ACT_LOAD));
          2:       add_item(random_item(ACT_RESTART));
          default: add_item(random_item(ACT_STEP));
        endcase
      end
      if (ep == 2) begin
        @(posedge clk);
        hold_req = 1'b1;
      end
    end

    drain_items();
    repeat (8) @(posedge clk);
    if (err_count == 0)
      $display("[grid_maze_walker_pledge] OK");
    else
      $display("[grid_maze_walker_pledge] ERROR");
    $finish;
  end

endmodule

/* filelist.f */
design/gmw_pkg.sv
design/gmw_ram.sv
design/gmw_step.sv
design/grid_maze_walker_pledge.sv
tb/grid_maze_walker_pledge_test.sv
